>>> hdl/pwmrds_pkg.sv
// shared types and constants for the pwm rate divider search block
// no dependencies; imported by every module of the block

package pwmrds_pkg;

   // field and datapath widths
   localparam int CLK_W   = 32;              // source clock in hertz
   localparam int TGT_W   = 20;              // target rate in hertz
   localparam int TOP_W   = 16;              // wrap value
   localparam int CNT_W   = TOP_W + 1;       // loop counter, also holds top+1
   localparam int DIV_W   = 12;              // divider in sixteenths (8.4)
   localparam int D_W     = TGT_W + CNT_W;   // target*(top+1)
   localparam int M_W     = 28;              // div16*(top+1)
   localparam int ERR_W   = 48;              // error numerator
   localparam int N_W     = CLK_W + 4;       // 16*clk
   localparam int MA_W    = 24;              // shared multiplier operand a
   localparam int MB_W    = 28;              // shared multiplier operand b
   localparam int MQ_W    = MA_W + MB_W;     // shared multiplier product
   localparam int X_W     = MQ_W + MA_W;     // full cross product
   localparam int DVD_W   = CLK_W + 6;       // 32*clk + d
   localparam int DVS_W   = CLK_W + 1;       // 2*d
   localparam int ERR10_W = ERR_W + 4;       // 10*err

   // register map and reset values
   localparam int CSR_AW = 3;
   localparam logic [0:0] REG_MIN_TOP = 1'b0;
   localparam logic [0:0] REG_MAX_TOP = 1'b1;
   localparam logic [TOP_W-1:0] MIN_TOP_RST = 16'd256;
   localparam logic [TOP_W-1:0] MAX_TOP_RST = 16'd8192;

   // search constants
   localparam logic [TOP_W-1:0] NO_FIT_TOP = 16'd1023;
   localparam logic [DIV_W-1:0] DIV16_MIN  = 12'd16;

   typedef struct packed {
      logic [CLK_W-1:0] clk_hz;
      logic [TGT_W-1:0] target_rate;
   } req_type;

   typedef struct packed {
      logic [TOP_W-1:0] wrap_top;
      logic [7:0]       div_int;
      logic [3:0]       div_frac;
      logic             found;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

>>> hdl/pwmrds_mul.sv
// shared multiplier of the search datapath, product registered
// depends on pwmrds_pkg

module pwmrds_mul (
   input  logic                          clock,
   input  logic [pwmrds_pkg::MA_W-1:0]   mul_a,
   input  logic [pwmrds_pkg::MB_W-1:0]   mul_b,
   output logic [pwmrds_pkg::MQ_W-1:0]   mul_q
);
   import pwmrds_pkg::*;

   logic [MQ_W-1:0] product_ff;
   logic [MQ_W-1:0] product_in;

   assign product_in = MQ_W'(mul_a) * MQ_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign mul_q = product_ff;

endmodule

>>> hdl/pwmrds_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit DIV_W bits
// depends on pwmrds_pkg

module pwmrds_div (
   input  logic                      clock,
   input  logic                      reset,
   input  pwmrds_pkg::div_req_type   div_req,
   output pwmrds_pkg::div_rsp_type   div_rsp
);
   import pwmrds_pkg::*;

   localparam int SH_W  = DVS_W + DIV_W - 1;
   localparam int CNT_B = $clog2(DIV_W);

   logic [DVD_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  dsh_ff, dsh_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [CNT_B-1:0] cnt_ff, cnt_in;
   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic             fits;

   assign fits = SH_W'(rem_ff) >= dsh_ff;

   always_comb begin
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (div_req.start) begin
         rem_in    = div_req.dividend;
         dsh_in    = {div_req.divisor, {(DIV_W-1){1'b0}}};
         quot_in   = '0;
         cnt_in    = CNT_B'(DIV_W - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff[DVD_W-1:0];
         end
         quot_in = {quot_ff[DIV_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_B'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> hdl/pwm_rate_divider_search_top.sv
// top level of the pwm rate divider search: csr port, search sequencer, result register
// depends on pwmrds_pkg, pwmrds_mul, pwmrds_div
//
// usage
// - a request transaction on req_ carries a source clock and a target rate in hertz;
//   the block walks wrap values from min_top to max_top and answers with one
//   rsp_ transaction: the wrap value and 8.4 clock divider whose rate is closest
//   to the target, or wrap 1023 with divider 0 and found low if none is legal
// - min_top and max_top sit at csr byte addresses 0 and 4; write them only while
//   no request is in flight
// - one request at a time: req_stall is low only while the sequencer is idle
// - per wrap value the shared multiplier and the bit-serial divider are reused
//   under the sequencer: a wrap value that the divider range rules out goes on
//   to the next; one that is scored waits on the divider, then makes multiplier
//   passes for the period, error and (once a best is held) the 76-bit cross product
// - the walk stops early at the first winner within 0.1 Hz
// - the result sits in an output register; a new request is taken while it
//   waits, and the next result is held back until rsp_stall lets the old one go
// - reset puts the sequencer in idle, drops rsp_valid and restores
//   min_top 256 and max_top 8192

module pwm_rate_divider_search_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pwmrds_pkg::req_type            req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pwmrds_pkg::rsp_type            rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pwmrds_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import pwmrds_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE   = 16'b0000_0000_0000_0001,
      S_START  = 16'b0000_0000_0000_0010,
      S_DPROD  = 16'b0000_0000_0000_0100,
      S_CHECK  = 16'b0000_0000_0000_1000,
      S_DIVIDE = 16'b0000_0000_0001_0000,
      S_MPROD  = 16'b0000_0000_0010_0000,
      S_TPROD  = 16'b0000_0000_0100_0000,
      S_X0     = 16'b0000_0000_1000_0000,
      S_X1     = 16'b0000_0001_0000_0000,
      S_X2     = 16'b0000_0010_0000_0000,
      S_X3     = 16'b0000_0100_0000_0000,
      S_X4     = 16'b0000_1000_0000_0000,
      S_CMP    = 16'b0001_0000_0000_0000,
      S_TAKE   = 16'b0010_0000_0000_0000,
      S_NEXT   = 16'b0100_0000_0000_0000,
      S_DONE   = 16'b1000_0000_0000_0000
   } state_type;

   // ---------------------------------------------------------------- csr
   logic [TOP_W-1:0] min_top_ff, min_top_in;
   logic [TOP_W-1:0] max_top_ff, max_top_in;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      min_top_in = min_top_ff;
      max_top_in = max_top_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MIN_TOP: min_top_in = csr_pwdata[TOP_W-1:0];
            REG_MAX_TOP: max_top_in = csr_pwdata[TOP_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIN_TOP: csr_prdata = 32'(min_top_ff);
         REG_MAX_TOP: csr_prdata = 32'(max_top_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- search state
   state_type          state_ff, state_in;
   logic [CLK_W-1:0]   clk_ff, clk_in;
   logic [TGT_W-1:0]   tgt_ff, tgt_in;
   logic [CNT_W-1:0]   top_ff, top_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [DIV_W-1:0]   q_ff, q_in;
   logic [M_W-1:0]     m_ff, m_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [MQ_W-1:0]    lo_ff, lo_in;
   logic [X_W-1:0]     lhs_ff, lhs_in;
   logic [X_W-1:0]     rhs_ff, rhs_in;
   logic [TOP_W-1:0]   win_top_ff, win_top_in;
   logic [DIV_W-1:0]   best_div16_ff, best_div16_in;
   logic [ERR_W-1:0]   win_err_ff, win_err_in;
   logic [M_W-1:0]     best_period_ff, best_period_in;
   logic               have_best_ff, have_best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // shared units
   logic [MA_W-1:0]    mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [MQ_W-1:0]    mul_q;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   pwmrds_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   pwmrds_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [CNT_W-1:0]     period;      // top + 1
   logic [N_W-1:0]       n_val;       // 16 * clk
   logic [D_W+12-1:0]    d_x4095;
   logic                 legal;
   logic [ERR_W-1:0]     tm_val;
   logic [ERR_W-1:0]     n_ext;
   logic [ERR10_W-1:0]   err_x10;
   logic                 req_take;

   assign period   = top_ff + CNT_W'(1);
   assign n_val    = {clk_ff, 4'b0000};
   assign d_x4095  = {d_ff, 12'b0} - (D_W+12)'(d_ff);
   // ideal divider must lie in 1 .. 255+15/16
   assign legal    = (d_ff != '0) && (D_W'(clk_ff) >= d_ff) &&
                     ((D_W+12)'(n_val) <= d_x4095);
   assign tm_val   = mul_q[ERR_W-1:0];
   assign n_ext    = ERR_W'(n_val);
   assign err_x10  = ERR10_W'({err_ff, 3'b000}) + ERR10_W'({err_ff, 1'b0});
   assign req_take = req_valid & ~req_stall;

   // divider is started from the check state: div16 = (32*clk + d) / (2*d)
   assign div_req.start    = (state_ff == S_CHECK) && legal;
   assign div_req.dividend = DVD_W'({clk_ff, 5'b00000}) + DVD_W'(d_ff);
   assign div_req.divisor  = {d_ff[CLK_W-1:0], 1'b0};

   // multiplier operand select; the registered product is read in the state that follows
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_START:  begin mul_a = MA_W'(tgt_ff);          mul_b = MB_W'(period);         end
         S_DIVIDE: begin mul_a = MA_W'(div_rsp.quot);    mul_b = MB_W'(period);         end
         S_MPROD:  begin mul_a = MA_W'(tgt_ff);          mul_b = mul_q[M_W-1:0];        end
         S_X0:     begin mul_a = err_ff[MA_W-1:0];       mul_b = best_period_ff;        end
         S_X1:     begin mul_a = err_ff[ERR_W-1:MA_W];   mul_b = best_period_ff;        end
         S_X2:     begin mul_a = win_err_ff[MA_W-1:0];   mul_b = m_ff;                  end
         S_X3:     begin mul_a = win_err_ff[ERR_W-1:MA_W]; mul_b = m_ff;                end
         default:  ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      clk_in         = clk_ff;
      tgt_in         = tgt_ff;
      top_in         = top_ff;
      d_in           = d_ff;
      q_in           = q_ff;
      m_in           = m_ff;
      err_in         = err_ff;
      lo_in          = lo_ff;
      lhs_in         = lhs_ff;
      rhs_in         = rhs_ff;
      win_top_in     = win_top_ff;
      best_div16_in  = best_div16_ff;
      win_err_in     = win_err_ff;
      best_period_in = best_period_ff;
      have_best_in   = have_best_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               clk_in         = req_data.clk_hz;
               tgt_in         = req_data.target_rate;
               top_in         = CNT_W'(min_top_ff);
               win_top_in     = NO_FIT_TOP;
               best_div16_in  = '0;
               win_err_in     = '0;
               best_period_in = '0;
               have_best_in   = 1'b0;
               state_in       = S_START;
            end
         end
         S_START: begin
            // empty range or walked past max_top
            if (top_ff > CNT_W'(max_top_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DPROD;
            end
         end
         S_DPROD: begin
            d_in     = mul_q[D_W-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = legal ? S_DIVIDE : S_NEXT;
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quot;
               state_in = (div_rsp.quot < DIV16_MIN) ? S_NEXT : S_MPROD;
            end
         end
         S_MPROD: begin
            m_in     = mul_q[M_W-1:0];
            state_in = S_TPROD;
         end
         S_TPROD: begin
            err_in   = (n_ext >= tm_val) ? (n_ext - tm_val) : (tm_val - n_ext);
            state_in = have_best_ff ? S_X0 : S_TAKE;
         end
         S_X0: begin
            state_in = S_X1;
         end
         S_X1: begin
            lo_in    = mul_q;
            state_in = S_X2;
         end
         S_X2: begin
            lhs_in   = {mul_q, {MA_W{1'b0}}} + X_W'(lo_ff);
            state_in = S_X3;
         end
         S_X3: begin
            lo_in    = mul_q;
            state_in = S_X4;
         end
         S_X4: begin
            rhs_in   = {mul_q, {MA_W{1'b0}}} + X_W'(lo_ff);
            state_in = S_CMP;
         end
         S_CMP: begin
            // strict improvement only: err*best_period < best_err*m
            state_in = (lhs_ff < rhs_ff) ? S_TAKE : S_NEXT;
         end
         S_TAKE: begin
            have_best_in   = 1'b1;
            win_top_in     = top_ff[TOP_W-1:0];
            best_div16_in  = q_ff;
            win_err_in     = err_ff;
            best_period_in = m_ff;
            // within 0.1 Hz: stop the walk
            state_in = (err_x10 <= ERR10_W'(m_ff)) ? S_DONE : S_NEXT;
         end
         S_NEXT: begin
            top_in   = top_ff + CNT_W'(1);
            state_in = S_START;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.wrap_top = win_top_ff;
               rsp_data_in.div_int  = have_best_ff ? best_div16_ff[DIV_W-1:4] : 8'd0;
               rsp_data_in.div_frac = have_best_ff ? best_div16_ff[3:0] : 4'd0;
               rsp_data_in.found    = have_best_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      clk_ff         <= clk_in;
      tgt_ff         <= tgt_in;
      top_ff         <= top_in;
      d_ff           <= d_in;
      q_ff           <= q_in;
      m_ff           <= m_in;
      err_ff         <= err_in;
      lo_ff          <= lo_in;
      lhs_ff         <= lhs_in;
      rhs_ff         <= rhs_in;
      best_div16_ff  <= best_div16_in;
      win_err_ff     <= win_err_in;
      best_period_ff <= best_period_in;
      rsp_data_ff    <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         min_top_ff   <= MIN_TOP_RST;
         max_top_ff   <= MAX_TOP_RST;
         win_top_ff   <= NO_FIT_TOP;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_top_ff   <= min_top_in;
         max_top_ff   <= max_top_in;
         win_top_ff   <= win_top_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
